/* rtl/core/assert_macros.svh */
// Assertion macros shared by the cluster caller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on clk, off while arst_n is low.
`define CRCC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Same-cycle implication.
`define CRCC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	`CRCC_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define CRCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	`CRCC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/core/crcc_pkg.sv */
// Types, widths and codes shared by the coverage run cluster caller.
package crcc_pkg;

	localparam int unsigned POS_BITS_DEF = 32;
	localparam logic [31:0] DEPTH_MAX    = 32'd65535;

	localparam int unsigned DEPTH_W   = 16;
	localparam int unsigned BASE_W    = 8;
	localparam int unsigned AVG_W     = 24;
	localparam int unsigned LEN_W     = 32;
	localparam int unsigned SUM_W     = 48;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned COORD_W   = 32;
	localparam int unsigned FRAC_BITS = 8;
	localparam int unsigned PROD_W    = AVG_W + LEN_W;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_AVG_Q8  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN_LEN = 2'd2;

	localparam logic [BASE_W-1:0] CH_A     = 8'h41;
	localparam logic [BASE_W-1:0] CH_C     = 8'h43;
	localparam logic [BASE_W-1:0] CH_G     = 8'h47;
	localparam logic [BASE_W-1:0] CH_T     = 8'h54;
	localparam logic [BASE_W-1:0] CASE_BIT = 8'h20;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_value;
		logic [BASE_W-1:0]  base_char;
	} crcc_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] cluster_first;
		logic [COORD_W-1:0] cluster_last;
		logic [SUM_W-1:0]   depth_sum;
		logic [CNT_W-1:0]   at_bases;
		logic [CNT_W-1:0]   gc_bases;
	} crcc_cluster_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] min_depth;
		logic [AVG_W-1:0]   min_avg_depth_q8;
		logic [LEN_W-1:0]   min_run_length;
	} crcc_cfg_t;

	// Closed run on its way to qualification
	typedef struct packed {
		logic [COORD_W-1:0] first;
		logic [COORD_W-1:0] last;
		logic [SUM_W-1:0]   sum;
		logic [LEN_W-1:0]   len;
		logic [CNT_W-1:0]   at;
		logic [CNT_W-1:0]   gc;
	} crcc_rec_t;

endpackage

/* rtl/core/crcc_run_tracker.sv */
// Input register and running run state; emits a record when a run closes.
module crcc_run_tracker #(
	parameter int unsigned POS_BITS = crcc_pkg::POS_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  crcc_pkg::crcc_cfg_t  cfg,
	input  logic                item_valid,
	output logic                item_stall,
	input  crcc_pkg::crcc_item_t item,
	output logic                rec_valid,
	input  logic                rec_stall,
	output crcc_pkg::crcc_rec_t  rec
);
	import crcc_pkg::*;

	logic               valid_s1;
	crcc_item_t         item_s1;
	logic               rec_valid_s2;
	crcc_rec_t          rec_s2;

	logic               inside_q;
	logic [POS_BITS-1:0] position_q;
	logic [COORD_W-1:0] first_q;
	logic [LEN_W-1:0]   len_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   at_q;
	logic [CNT_W-1:0]   gc_q;

	logic               rec_free;
	logic               s1_free;
	logic               step;
	logic               accept;
	logic [DEPTH_W-1:0] depth;
	logic               hit;
	logic               close;
	logic               is_at;
	logic               is_gc;
	logic [LEN_W-1:0]   len_base;
	logic [SUM_W-1:0]   sum_base;
	logic [CNT_W-1:0]   at_base;
	logic [CNT_W-1:0]   gc_base;
	logic [LEN_W-1:0]   len_next;
	logic [SUM_W:0]     sum_wide;
	logic [SUM_W-1:0]   sum_next;
	logic [CNT_W-1:0]   at_next;
	logic [CNT_W-1:0]   gc_next;
	logic [POS_BITS-1:0] pos_prev;

	assign rec_free   = !rec_valid_s2 || !rec_stall;
	assign s1_free    = !valid_s1 || rec_free;
	assign step       = valid_s1 && rec_free;
	assign accept     = item_valid && s1_free;
	assign item_stall = !s1_free;

	always_comb begin
		if (32'(item_s1.depth_value) > DEPTH_MAX) begin
			depth = DEPTH_MAX[DEPTH_W-1:0];
		end else begin
			depth = item_s1.depth_value;
		end
	end

	assign hit   = depth >= cfg.min_depth;
	assign close = !hit && inside_q;
	assign is_at = item_s1.base_char inside {CH_A, CH_T, CH_A | CASE_BIT, CH_T | CASE_BIT};
	assign is_gc = item_s1.base_char inside {CH_C, CH_G, CH_C | CASE_BIT, CH_G | CASE_BIT};

	// A fresh run starts from zero
	assign len_base = inside_q ? len_q : '0;
	assign sum_base = inside_q ? sum_q : '0;
	assign at_base  = inside_q ? at_q  : '0;
	assign gc_base  = inside_q ? gc_q  : '0;

	assign len_next = (&len_base) ? len_base : len_base + LEN_W'(1);
	assign sum_wide = {1'b0, sum_base} + (SUM_W + 1)'(depth);
	assign sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
	assign at_next  = (is_at && !(&at_base)) ? at_base + CNT_W'(1) : at_base;
	assign gc_next  = (is_gc && !(&gc_base)) ? gc_base + CNT_W'(1) : gc_base;
	assign pos_prev = position_q - POS_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rec_valid_s2 <= 1'b0;
			inside_q     <= 1'b0;
			position_q   <= '0;
		end else begin
			if (s1_free) begin
				valid_s1 <= item_valid;
			end
			if (rec_free) begin
				rec_valid_s2 <= step && close;
			end
			if (step) begin
				inside_q   <= hit;
				position_q <= position_q + POS_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (step && hit) begin
			if (!inside_q) begin
				first_q <= COORD_W'(position_q);
			end
			len_q <= len_next;
			sum_q <= sum_next;
			at_q  <= at_next;
			gc_q  <= gc_next;
		end
		if (step && close) begin
			rec_s2.first <= first_q;
			rec_s2.last  <= COORD_W'(pos_prev);
			rec_s2.sum   <= sum_q;
			rec_s2.len   <= len_q;
			rec_s2.at    <= at_q;
			rec_s2.gc    <= gc_q;
		end
	end

	assign rec_valid = rec_valid_s2;
	assign rec       = rec_s2;

endmodule

/* rtl/core/crcc_qualify.sv */
// Length and average depth tests on closed runs, and the result register.
module crcc_qualify (
	input  logic                  clk,
	input  logic                  arst_n,
	input  crcc_pkg::crcc_cfg_t    cfg,
	input  logic                  rec_valid,
	output logic                  rec_stall,
	input  crcc_pkg::crcc_rec_t    rec,
	output logic                  prod_valid,
	output logic                  cluster_valid,
	input  logic                  cluster_stall,
	output crcc_pkg::crcc_cluster_t cluster
);
	import crcc_pkg::*;

	logic                      valid_s3;
	crcc_rec_t                 rec_s3;
	logic [PROD_W-1:0]         prod_s3;
	logic                      long_s3;
	logic                      out_valid_q;
	crcc_cluster_t             cluster_q;

	logic                      out_free;
	logic                      s3_free;
	logic [PROD_W-1:0]         prod;
	logic [SUM_W+FRAC_BITS-1:0] sum_q8;
	logic                      pass;

	assign out_free  = !out_valid_q || !cluster_stall;
	assign s3_free   = !valid_s3 || out_free;
	assign rec_stall = !s3_free;

	assign prod   = PROD_W'(cfg.min_avg_depth_q8) * PROD_W'(rec.len);
	assign sum_q8 = {rec_s3.sum, FRAC_BITS'(0)};
	assign pass   = long_s3 && (PROD_W'(sum_q8) >= prod_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s3_free) begin
				valid_s3 <= rec_valid;
			end
			// drop runs that fail either test
			if (out_free) begin
				out_valid_q <= valid_s3 && pass;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid && s3_free) begin
			rec_s3  <= rec;
			prod_s3 <= prod;
			long_s3 <= rec.len >= cfg.min_run_length;
		end
		if (valid_s3 && out_free && pass) begin
			cluster_q.cluster_first <= rec_s3.first;
			cluster_q.cluster_last  <= rec_s3.last;
			cluster_q.depth_sum     <= rec_s3.sum;
			cluster_q.at_bases      <= rec_s3.at;
			cluster_q.gc_bases      <= rec_s3.gc;
		end
	end

	assign prod_valid    = valid_s3;
	assign cluster_valid = out_valid_q;
	assign cluster       = cluster_q;

endmodule

/* rtl/core/coverage_run_cluster_caller_core.sv */
// Coverage run cluster caller: one position per beat, at most one cluster out
// per beat. A beat is accepted every cycle unless the result side backs up all
// the way; the pace is set by the update of the run state (length, 48-bit
// depth sum, base counts). A cluster comes out after the beat of the first
// shallow position that closes its run passes the input register, the run
// stage, a stage for the 24x32 average-depth product, then the result register.
// Runs still open when the stream stops are never reported. No clearing pass
// after reset. Write configuration only while the pipeline is drained.
module coverage_run_cluster_caller_core #(
	parameter int unsigned POS_BITS = crcc_pkg::POS_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [crcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crcc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  crcc_pkg::crcc_item_t          item,
	output logic                         cluster_valid,
	input  logic                         cluster_stall,
	output crcc_pkg::crcc_cluster_t       cluster
);
	import crcc_pkg::*;

`include "assert_macros.svh"

	crcc_cfg_t cfg_q;
	logic      rec_valid;
	logic      rec_stall;
	crcc_rec_t rec;
	logic      prod_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_depth        <= DEPTH_W'(1);
			cfg_q.min_avg_depth_q8 <= '0;
			cfg_q.min_run_length   <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_DEPTH:   cfg_q.min_depth        <= cfg_data[DEPTH_W-1:0];
				CFG_MIN_AVG_Q8:  cfg_q.min_avg_depth_q8 <= cfg_data[AVG_W-1:0];
				CFG_MIN_RUN_LEN: cfg_q.min_run_length   <= cfg_data[LEN_W-1:0];
				default: begin
					// ignore writes past the register list
				end
			endcase
		end
	end

	crcc_run_tracker #(
		.POS_BITS (POS_BITS)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec        (rec)
	);

	crcc_qualify u_qualify (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.rec_valid     (rec_valid),
		.rec_stall     (rec_stall),
		.rec           (rec),
		.prod_valid    (prod_valid),
		.cluster_valid (cluster_valid),
		.cluster_stall (cluster_stall),
		.cluster       (cluster)
	);

	`CRCC_ASSERT_NEXT(a_rec_hold, rec_valid && rec_stall, rec_valid && $stable(rec), "closed run record moved while held")
	`CRCC_ASSERT_IMPLY(a_stall_cause, item_stall, cluster_valid && cluster_stall, "input stalled with result side free")
	`CRCC_ASSERT_IMPLY(a_out_source, $rose(cluster_valid), $past(prod_valid), "cluster appeared without a qualified run")

endmodule

/* tb/coverage_run_cluster_caller_core_tb.sv */
// Self-checking testbench for the coverage run cluster caller core.
`timescale 1ns / 1ps

module coverage_run_cluster_caller_core_tb;
	import crcc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned MAX_GAP = 11;
	localparam int unsigned TAIL_CYCLES = 10;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	logic                  item_stall;
	crcc_item_t            item;
	logic                  cluster_valid;
	logic                  cluster_stall;
	crcc_cluster_t         cluster;

	// Predictor copy of the configuration and run state
	logic [DEPTH_W-1:0] thr_depth;
	logic [AVG_W-1:0]   thr_avg;
	logic [LEN_W-1:0]   thr_len;
	logic               in_run;
	logic [31:0]        pos;
	logic [31:0]        run_start;
	logic [LEN_W-1:0]   run_len;
	logic [SUM_W-1:0]   run_sum;
	logic [CNT_W-1:0]   run_at_n;
	logic [CNT_W-1:0]   run_gc_n;

	crcc_cluster_t pending_clusters[$];
	int unsigned   error_count;
	bit            idle_on;
	int unsigned   rx_gap_left;
	int unsigned   hold_reqs;

	coverage_run_cluster_caller_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.cluster_valid (cluster_valid),
		.cluster_stall (cluster_stall),
		.cluster       (cluster)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic void track_position(input logic [DEPTH_W-1:0] d,
			input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] up;
		logic [SUM_W:0]    wide;
		logic [63:0]       scaled;
		logic [63:0]       bar;
		crcc_cluster_t     c;
		up = (b >= (CH_A | CASE_BIT) && b <= 8'h7A) ? b - CASE_BIT : b;
		if (d >= thr_depth) begin
			if (!in_run) begin
				in_run = 1'b1;
				run_start = pos;
				run_len = '0;
				run_sum = '0;
				run_at_n = '0;
				run_gc_n = '0;
			end
			if (run_len != '1)
				run_len = run_len + 1'b1;
			wide = {1'b0, run_sum} + d;
			run_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
			if (up == CH_A || up == CH_T) begin
				if (run_at_n != '1)
					run_at_n = run_at_n + 1'b1;
			end else if (up == CH_C || up == CH_G) begin
				if (run_gc_n != '1)
					run_gc_n = run_gc_n + 1'b1;
			end
		end else if (in_run) begin
			scaled = {8'b0, run_sum, 8'b0};
			bar = 64'(thr_avg) * 64'(run_len);
			if (run_len >= thr_len && scaled >= bar) begin
				c.cluster_first = run_start;
				c.cluster_last = pos - 1'b1;
				c.depth_sum = run_sum;
				c.at_bases = run_at_n;
				c.gc_bases = run_gc_n;
				pending_clusters.insert(pending_clusters.size(), c);
			end
			in_run = 1'b0;
			run_len = '0;
			run_sum = '0;
			run_at_n = '0;
			run_gc_n = '0;
		end
		pos = pos + 1'b1;
	endfunction

	// Send one position beat; enter and leave at a falling edge
	task automatic send_position(input logic [DEPTH_W-1:0] d, input logic [BASE_W-1:0] b);
		int unsigned gap;
		gap = idle_on ? $urandom_range(MAX_GAP) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= '{depth_value: d, base_char: b};
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		track_position(d, b);
		@(negedge clk);
	endtask

	// Drop valid, wait out pending clusters and the pipeline tail
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_clusters.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MIN_DEPTH:   thr_depth = data[DEPTH_W-1:0];
			CFG_MIN_AVG_Q8:  thr_avg = data[AVG_W-1:0];
			CFG_MIN_RUN_LEN: thr_len = data[LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Result checker and receiver gap draw
	always @(posedge clk) begin
		crcc_cluster_t want;
		if (arst_n && cluster_valid && !cluster_stall) begin
			if (pending_clusters.size() == 0) begin
				flag_mismatch("cluster with none pending", cluster.cluster_first, '0);
			end else begin
				want = pending_clusters.pop_front();
				if (cluster.cluster_first !== want.cluster_first)
					flag_mismatch("cluster_first", cluster.cluster_first, want.cluster_first);
				if (cluster.cluster_last !== want.cluster_last)
					flag_mismatch("cluster_last", cluster.cluster_last, want.cluster_last);
				if (cluster.depth_sum !== want.depth_sum)
					flag_mismatch("depth_sum", cluster.depth_sum, want.depth_sum);
				if (cluster.at_bases !== want.at_bases)
					flag_mismatch("at_bases", cluster.at_bases, want.at_bases);
				if (cluster.gc_bases !== want.gc_bases)
					flag_mismatch("gc_bases", cluster.gc_bases, want.gc_bases);
			end
			rx_gap_left = idle_on ? $urandom_range(MAX_GAP) : 0;
		end
	end

	// Receiver stall driver, with the long hold counted here
	initial begin
		int unsigned hold_seen;
		int unsigned hold_left;
		hold_seen = 0;
		hold_left = 0;
		cluster_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				cluster_stall <= 1'b1;
				hold_left--;
			end else if (rx_gap_left > 0) begin
				cluster_stall <= 1'b1;
				rx_gap_left--;
			end else begin
				cluster_stall <= 1'b0;
			end
		end
	end

	task automatic test_default_setup();
		idle_on = 1'b1;
		send_position(16'd0, CH_A);
		send_position(16'd1, CH_A);
		send_position(16'hFFFF, CH_T | CASE_BIT);
		send_position(16'd2, CH_C | CASE_BIT);
		send_position(16'd3, CH_G);
		// bytes just outside the lower-case range count as neither
		send_position(16'd4, 8'h60);
		send_position(16'd5, 8'h7B);
		send_position(16'd0, 8'hFF);
		send_position(16'd7, CH_G | CASE_BIT);
		send_position(16'd0, CH_A | CASE_BIT);
		settle();
	endtask

	task automatic test_register_edges();
		idle_on = 1'b0;
		write_register(CFG_UNUSED, '1);
		send_position(16'd1, CH_C);
		send_position(16'd0, CH_A);
		settle();
		// upper data bits drop, leaving a zero depth threshold
		write_register(CFG_MIN_DEPTH, 32'hABCD_0000);
		send_position(16'd0, CH_T);
		send_position(16'd0, CH_G);
		send_position(16'd0, 8'h00);
		settle();
		write_register(CFG_MIN_DEPTH, 32'h0000_FFFF);
		send_position(16'hFFFF, CH_A);
		send_position(16'hFFFE, CH_C);
		settle();
	endtask

	task automatic test_length_limits();
		idle_on = 1'b1;
		write_register(CFG_MIN_DEPTH, 32'h1234_0064);
		write_register(CFG_MIN_RUN_LEN, 32'd0);
		send_position(16'd100, CH_G);
		send_position(16'd99, CH_T);
		settle();
		write_register(CFG_MIN_RUN_LEN, '1);
		repeat (3) send_position(16'd200, CH_A);
		send_position(16'd0, CH_C);
		settle();
		write_register(CFG_MIN_RUN_LEN, 32'd3);
		repeat (3) send_position(16'd150, CH_T);
		send_position(16'd1, CH_G);
		settle();
	endtask

	task automatic test_average_boundary();
		idle_on = 1'b0;
		write_register(CFG_MIN_RUN_LEN, 32'd1);
		// average exactly at the threshold passes, one step above fails
		write_register(CFG_MIN_AVG_Q8, 32'hFF00_6400);
		send_position(16'd100, CH_A);
		send_position(16'd100, CH_C);
		send_position(16'd50, CH_A);
		settle();
		write_register(CFG_MIN_AVG_Q8, 32'h0000_6401);
		send_position(16'd100, CH_A);
		send_position(16'd100, CH_C);
		send_position(16'd50, CH_A);
		settle();
		write_register(CFG_MIN_AVG_Q8, 32'h00FF_FFFF);
		send_position(16'hFFFF, CH_G);
		send_position(16'hFFFF, CH_T);
		send_position(16'd0, CH_A);
		settle();
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		write_register(CFG_MIN_DEPTH, 32'd10);
		write_register(CFG_MIN_AVG_Q8, 32'd0);
		write_register(CFG_MIN_RUN_LEN, 32'd1);
		hold_reqs++;
		repeat (40) begin
			send_position(16'($urandom_range(16'hFFFF, 10)), CH_A);
			send_position(16'($urandom_range(9)), CH_C);
		end
		settle();
	endtask

	function automatic logic [BASE_W-1:0] pick_base();
		logic [BASE_W-1:0] b;
		case ($urandom_range(3))
			0: b = CH_A;
			1: b = CH_C;
			2: b = CH_G;
			default: b = CH_T;
		endcase
		if ($urandom_range(1))
			b = b | CASE_BIT;
		if ($urandom_range(99) < 30)
			b = 8'($urandom_range(255));
		return b;
	endfunction

	task automatic test_random_runs(input int unsigned n_items, input bit idle);
		int unsigned sent;
		int unsigned thr;
		int unsigned run_n;
		logic [AVG_W-1:0] avg;
		idle_on = idle;
		thr = ($urandom_range(3) == 0) ? $urandom_range(16, 1) : $urandom_range(60000, 1);
		if ($urandom_range(2) == 0)
			avg = '0;
		else
			avg = AVG_W'($urandom_range(16'hFFFF, thr) * 256 + $urandom_range(255));
		write_register(CFG_MIN_DEPTH, {16'($urandom_range(16'hFFFF)), 16'(thr)});
		write_register(CFG_MIN_AVG_Q8, {8'($urandom_range(255)), avg});
		write_register(CFG_MIN_RUN_LEN, 32'($urandom_range(6)));
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 15) begin
				send_position(16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
				sent++;
			end else begin
				run_n = $urandom_range(12, 1);
				repeat (run_n) send_position(16'($urandom_range(16'hFFFF, thr)), pick_base());
				send_position(16'($urandom_range(thr - 1)), pick_base());
				sent += run_n + 1;
			end
		end
		settle();
	endtask

	initial begin
		error_count = 0;
		idle_on = 1'b0;
		rx_gap_left = 0;
		hold_reqs = 0;
		thr_depth = 16'd1;
		thr_avg = '0;
		thr_len = 32'd1;
		in_run = 1'b0;
		pos = '0;
		run_start = '0;
		run_len = '0;
		run_sum = '0;
		run_at_n = '0;
		run_gc_n = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MIN_DEPTH;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_setup();
		test_register_edges();
		test_length_limits();
		test_average_boundary();
		test_backpressure();
		test_random_runs(190, 1'b1);
		test_random_runs(190, 1'b0);
		test_random_runs(190, 1'b1);
		test_random_runs(190, 1'b0);
		test_random_runs(190, 1'b1);

		settle();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* coverage_run_cluster_caller_core.f */
+incdir+rtl/core
rtl/core/crcc_pkg.sv
rtl/core/crcc_run_tracker.sv
rtl/core/crcc_qualify.sv
rtl/core/coverage_run_cluster_caller_core.sv
tb/coverage_run_cluster_caller_core_tb.sv
